FILE: hw/rtl/bdar_pkg.sv
// Shared types and constants for the button debounce / auto-repeat block.
// Used by bdar_lane and button_debounce_autorepeat; depends on nothing.
package bdar_pkg;

   localparam int FIELD_W     = 5;   // width of the button mask fields
   localparam int COUNT_W     = 8;   // width of every per-button counter
   localparam int CSR_DATA_W  = 8;   // widest configuration register
   localparam int CSR_INDEX_W = 2;
   localparam int BUTTONS_DEF = 5;

   localparam logic [COUNT_W-1:0] HOLD_MAX = 8'd255;

   // register reset values
   localparam logic [COUNT_W-1:0] DEBOUNCE_RST = 8'd2;
   localparam logic [COUNT_W-1:0] START_RST    = 8'd15;
   localparam logic [COUNT_W-1:0] INTERVAL_RST = 8'd3;
   localparam logic [FIELD_W-1:0] REPEAT_RST   = 5'd15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_FRAMES    = 2'd0,
      CSR_REPEAT_START       = 2'd1,
      CSR_REPEAT_PERIOD      = 2'd2,
      CSR_REPEAT_ENABLE_MASK = 2'd3
   } csr_index_type;

   // timing settings shared by all lanes, zero debounce and interval counts already forced to one
   typedef struct packed {
      logic [COUNT_W-1:0] need;
      logic [COUNT_W-1:0] start;
      logic [COUNT_W-1:0] step;
   } lane_cfg_type;

endpackage

FILE: hw/rtl/bdar_lane.sv
// One button lane: debounce counter, hold counter and repeat phase.
// Depends on bdar_pkg for counter widths and the lane settings struct.
module bdar_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  raw,
   input  logic                  repeat_on,
   input  bdar_pkg::lane_cfg_type cfg,
   output logic                  held,
   output logic                  pulse
);

   logic [bdar_pkg::COUNT_W-1:0] debounce_ff, debounce_in;
   logic [bdar_pkg::COUNT_W-1:0] hold_ff, hold_in;
   logic [bdar_pkg::COUNT_W-1:0] phase_ff, phase_in;
   logic                         held_ff, held_in;
   logic [bdar_pkg::COUNT_W:0]   phase_inc;

   always_comb begin
      if (!raw) begin
         debounce_in = '0;
      end else if (debounce_ff < cfg.need) begin
         debounce_in = debounce_ff + 1'b1;
      end else begin
         debounce_in = debounce_ff;
      end

      held_in = (debounce_in >= cfg.need);

      if (!held_in) begin
         hold_in = '0;
      end else if (hold_ff < bdar_pkg::HOLD_MAX) begin
         hold_in = hold_ff + 1'b1;
      end else begin
         hold_in = hold_ff;
      end

      pulse     = held_in && !held_ff;
      phase_inc = {1'b0, phase_ff} + 1'b1;
      if (held_in && (hold_in >= cfg.start)) begin
         if (repeat_on && (phase_ff == '0)) begin
            pulse = 1'b1;
         end
         // wrap at the interval; a phase left above a shrunk interval drops to zero
         if (phase_inc >= {1'b0, cfg.step}) begin
            phase_in = '0;
         end else begin
            phase_in = phase_inc[bdar_pkg::COUNT_W-1:0];
         end
      end else begin
         phase_in = '0;
      end
   end

   assign held = held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= '0;
         hold_ff     <= '0;
         phase_ff    <= '0;
         held_ff     <= 1'b0;
      end else if (advance) begin
         debounce_ff <= debounce_in;
         hold_ff     <= hold_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
      end
   end

endmodule

FILE: hw/rtl/button_debounce_autorepeat.sv
// Button debounce and auto-repeat, top level.
// Depends on bdar_pkg and instantiates one bdar_lane per button.
//
// Each accepted req word is one frame tick carrying the raw pressed level of
// up to five buttons; each produces exactly one rsp word with the debounced
// held mask and a pressed mask that pulses on a new press and, for buttons
// enabled in repeat_enable_mask, at repeat start and every repeat period of
// frames after (the period holds after the 255-frame hold counter
// saturates). A word waits in the input register until the output register
// is free or draining, and all lanes update in parallel as it moves on; it
// then sits in the output register until taken. While rsp_stall is low,
// one word per cycle is sustained, since every lane finishes its frame
// as the word advances. A stalled rsp side backs up into req_stall
// only once the input register is also full.
// Debounce or interval settings of zero act as one. Write the csr_ registers
// only while no word is in flight; button lanes past the fifth see no presses.
module button_debounce_autorepeat #(
   parameter int BUTTONS = bdar_pkg::BUTTONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_enable,
   input  logic [bdar_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdar_pkg::CSR_DATA_W-1:0]    csr_data,
   // frame tick in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdar_pkg::FIELD_W-1:0]       req_raw_level_mask,
   // result out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdar_pkg::FIELD_W-1:0]       rsp_held_mask,
   output logic [bdar_pkg::FIELD_W-1:0]       rsp_pressed_mask
);

   localparam int FW    = bdar_pkg::FIELD_W;
   localparam int VEC_W = (BUTTONS > FW) ? BUTTONS : FW;

   // configuration registers
   logic [bdar_pkg::COUNT_W-1:0] debounce_ff, start_ff, interval_ff;
   logic [FW-1:0]                repeat_mask_ff;
   bdar_pkg::lane_cfg_type       lane_cfg;

   // input stage
   logic          in_valid_ff, in_valid_in;
   logic [FW-1:0] raw_ff;
   logic          advance;
   logic          req_take;

   // output stage
   logic          out_valid_ff, out_valid_in;
   logic [FW-1:0] held_out_ff, pressed_out_ff;

   logic [VEC_W-1:0] held_vec, pulse_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= bdar_pkg::DEBOUNCE_RST;
         start_ff       <= bdar_pkg::START_RST;
         interval_ff    <= bdar_pkg::INTERVAL_RST;
         repeat_mask_ff <= bdar_pkg::REPEAT_RST;
      end else if (csr_write_enable) begin
         case (bdar_pkg::csr_index_type'(csr_index))
            bdar_pkg::CSR_DEBOUNCE_FRAMES:    debounce_ff    <= csr_data;
            bdar_pkg::CSR_REPEAT_START:       start_ff       <= csr_data;
            bdar_pkg::CSR_REPEAT_PERIOD:      interval_ff    <= csr_data;
            bdar_pkg::CSR_REPEAT_ENABLE_MASK: repeat_mask_ff <= csr_data[FW-1:0];
            default: ;
         endcase
      end
   end

   // force zero debounce and interval counts to one before they reach the lanes
   always_comb begin
      lane_cfg.need  = (debounce_ff == '0) ? 8'd1 : debounce_ff;
      lane_cfg.start = start_ff;
      lane_cfg.step  = (interval_ff == '0) ? 8'd1 : interval_ff;
   end

   // advance the input stage whenever the output register is free or draining
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff <= req_raw_level_mask;
      end
      if (advance) begin
         held_out_ff    <= held_vec[FW-1:0];
         pressed_out_ff <= pulse_vec[FW-1:0];
      end
   end

   for (genvar i = 0; i < VEC_W; i++) begin : g_lane
      if (i < BUTTONS) begin : g_on
         logic raw_bit, rep_bit;
         if (i < FW) begin : g_field
            assign raw_bit = raw_ff[i];
            assign rep_bit = repeat_mask_ff[i];
         end else begin : g_extra
            assign raw_bit = 1'b0;
            assign rep_bit = 1'b0;
         end
         bdar_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .raw       (raw_bit),
            .repeat_on (rep_bit),
            .cfg       (lane_cfg),
            .held      (held_vec[i]),
            .pulse     (pulse_vec[i])
         );
      end else begin : g_off
         assign held_vec[i]  = 1'b0;
         assign pulse_vec[i] = 1'b0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_held_mask    = held_out_ff;
   assign rsp_pressed_mask = pressed_out_ff;

   // a press pulse only ever comes from a held button
   a_pulse_needs_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pressed_mask & ~rsp_held_mask) == '0))
      else $error("pressed bit without held bit");

   // a word leaving the input stage lands in the output register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced word lost");

   // back-pressure only with a word parked in the input stage
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("req_stall without a blocked word");

endmodule
